/* sv/usable_range_sort_merge_top_assert.svh */
// Assertion macros shared by the usable range sort/merge RTL.
// Included by the controller and datapath; needs no other file.
`ifndef USABLE_RANGE_SORT_MERGE_TOP_ASSERT_SVH
`define USABLE_RANGE_SORT_MERGE_TOP_ASSERT_SVH

`ifndef SYNTH
// Property check on the rising clock, off while reset is asserted
`define URS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication check: cause in a cycle requires effect in that cycle
`define URS_ASSERT_IMPL(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error(msg);
// Next-cycle check: cause in a cycle requires effect in the following cycle
`define URS_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);
`else
`define URS_ASSERT(label, clk, rst_n, prop, msg)
`define URS_ASSERT_IMPL(label, clk, rst_n, cause, effect, msg)
`define URS_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg)
`endif

`endif

/* sv/urs_pkg.sv */
// Package for the usable range sort/merge block: constants and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package urs_pkg;

    // Region type code for available RAM
    localparam logic [31:0] TYPE_AVAILABLE = 32'd1;

    // Reset value of the usable limit register
    localparam logic [31:0] LIMIT_RESET = 32'h2000_0000;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;       // input transaction taken this cycle
        logic add_default;  // add [0, limit) if the store is empty and limit is nonzero
        logic scan_rd;      // read store at scan address, advance
        logic merge;        // fold selected minimum into merge state
        logic emit_final;   // load last merged range into output
        logic emit_empty;   // load empty-list result into output
        logic clear;        // reset store state for the next map
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;       // nothing stored
        logic scan_last;        // scan address is the last stored entry
        logic picks_last;       // current pick is the last one
        logic merge_needs_out;  // next merge step emits a range
        logic out_free;         // output register can load this cycle
    } t_stat;

endpackage

`default_nettype wire

/* sv/urs_dpath.sv */
// Datapath of the usable range sort/merge block: entry filter, range store,
// minimum-selection scan, merge registers and output register. Uses urs_pkg.
`default_nettype none
`include "usable_range_sort_merge_top_assert.svh"

module urs_dpath #(
    parameter int MAX_RANGES = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire urs_pkg::t_cmd i_cmd,
    output urs_pkg::t_stat     o_stat,
    input  wire logic [31:0]   i_limit,
    input  wire logic          i_entry_valid,
    input  wire logic [63:0]   i_entry_addr,
    input  wire logic [63:0]   i_entry_len,
    input  wire logic [31:0]   i_entry_type,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic               o_range_valid,
    output logic [31:0]        o_range_start,
    output logic [31:0]        o_range_end,
    output logic               o_range_last,
    output logic               o_ranges_dropped
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

    // Range store
    logic [31:0] r_mem_s [MAX_RANGES];
    logic [31:0] r_mem_e [MAX_RANGES];

    logic [CW-1:0]         r_count;
    logic                  r_dropped;
    logic                  r_keep;
    logic [31:0]           r_lo;
    logic [31:0]           r_hi;
    logic [IW-1:0]         r_scan_addr;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic [31:0]           r_rd_s;
    logic [31:0]           r_rd_e;
    logic                  r_best_vld;
    logic [IW-1:0]         r_best_idx;
    logic [31:0]           r_best_s;
    logic [31:0]           r_best_e;
    logic [MAX_RANGES-1:0] r_used;
    logic [CW-1:0]         r_pick;
    logic                  r_cur_vld;
    logic [31:0]           r_cur_s;
    logic [31:0]           r_cur_e;
    logic                  r_o_vld;
    logic                  r_o_rvld;
    logic [31:0]           r_o_s;
    logic [31:0]           r_o_e;
    logic                  r_o_last;
    logic                  r_o_drop;

    logic [64:0]   sum;
    logic          below;
    logic          f_keep;
    logic [31:0]   f_hi;
    logic          full;
    logic          def_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_lo;
    logic [31:0]   wr_hi;
    logic          out_take;
    logic          out_free;
    logic          needs_out;
    logic          take_rd;

    // Entry filter: start below limit, 65-bit end clipped at the limit
    always_comb begin
        sum    = {1'b0, i_entry_addr} + {1'b0, i_entry_len};
        below  = (i_entry_addr[63:32] == 32'd0) && (i_entry_addr[31:0] < i_limit);
        f_keep = i_entry_valid && (i_entry_len != 64'd0)
                 && (i_entry_type == urs_pkg::TYPE_AVAILABLE) && below;
        f_hi   = (sum > {33'd0, i_limit}) ? i_limit : sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
        end else begin
            r_keep <= i_cmd.accept && f_keep;
        end
        r_lo <= i_entry_addr[31:0];
        r_hi <= f_hi;
    end

    // Store write: filtered range or default range
    always_comb begin
        full    = (r_count >= MAX_CNT);
        def_en  = i_cmd.add_default && (r_count == '0) && (i_limit != 32'd0);
        wr_en   = (r_keep && !full) || def_en;
        wr_addr = def_en ? '0 : r_count[IW-1:0];
        wr_lo   = def_en ? 32'd0 : r_lo;
        wr_hi   = def_en ? i_limit : r_hi;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_s[wr_addr] <= wr_lo;
            r_mem_e[wr_addr] <= wr_hi;
        end
        if (i_cmd.scan_rd) begin
            r_rd_s <= r_mem_s[r_scan_addr];
            r_rd_e <= r_mem_e[r_scan_addr];
        end
        r_rd_idx <= r_scan_addr;
    end

    // Count and sticky drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
            if (r_keep && full) begin
                r_dropped <= 1'b1;
            end
        end
    end

    // Minimum-selection scan over unused entries
    assign take_rd = r_rd_vld && !r_used[r_rd_idx] && (!r_best_vld || (r_rd_s < r_best_s));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_used      <= '0;
            r_pick      <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.merge) begin
                r_scan_addr         <= '0;
                r_best_vld          <= 1'b0;
                r_used[r_best_idx]  <= 1'b1;
                r_pick              <= r_pick + CW'(1);
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_addr <= r_scan_addr + IW'(1);
                end
                if (take_rd) begin
                    r_best_vld <= 1'b1;
                end
            end
        end
        if (take_rd) begin
            r_best_idx <= r_rd_idx;
            r_best_s   <= r_rd_s;
            r_best_e   <= r_rd_e;
        end
    end

    // Merge state: current open range
    assign needs_out = r_cur_vld && (r_best_s > r_cur_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cur_vld <= 1'b0;
        end else if (i_cmd.merge) begin
            r_cur_vld <= 1'b1;
        end
        if (i_cmd.merge) begin
            if (!r_cur_vld || needs_out) begin
                r_cur_s <= r_best_s;
                r_cur_e <= r_best_e;
            end else if (r_best_e > r_cur_e) begin
                r_cur_e <= r_best_e;
            end
        end
    end

    // Output register
    assign out_take = r_o_vld && !i_out_stall;
    assign out_free = !r_o_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if ((i_cmd.merge && needs_out) || i_cmd.emit_final || i_cmd.emit_empty) begin
            r_o_vld <= 1'b1;
        end else if (out_take) begin
            r_o_vld <= 1'b0;
        end
        if (i_cmd.merge && needs_out) begin
            r_o_rvld <= 1'b1;
            r_o_s    <= r_cur_s;
            r_o_e    <= r_cur_e;
            r_o_last <= 1'b0;
            r_o_drop <= r_dropped;
        end else if (i_cmd.emit_final) begin
            r_o_rvld <= 1'b1;
            r_o_s    <= r_cur_s;
            r_o_e    <= r_cur_e;
            r_o_last <= 1'b1;
            r_o_drop <= r_dropped;
        end else if (i_cmd.emit_empty) begin
            r_o_rvld <= 1'b0;
            r_o_s    <= 32'd0;
            r_o_e    <= 32'd0;
            r_o_last <= 1'b1;
            r_o_drop <= r_dropped;
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_range_valid    = r_o_rvld;
    assign o_range_start    = r_o_s;
    assign o_range_end      = r_o_e;
    assign o_range_last     = r_o_last;
    assign o_ranges_dropped = r_o_drop;

    // Status to controller
    always_comb begin
        o_stat.count_zero      = (r_count == '0);
        o_stat.scan_last       = (CW'(r_scan_addr) == (r_count - CW'(1)));
        o_stat.picks_last      = (r_pick == (r_count - CW'(1)));
        o_stat.merge_needs_out = needs_out;
        o_stat.out_free        = out_free;
    end

    `URS_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= MAX_CNT, "store count above capacity")
    `URS_ASSERT(a_used_le_count, i_clk, i_rst_n, $countones(r_used) <= r_count, "more picks than entries")
    `URS_ASSERT_IMPL(a_wr_room, i_clk, i_rst_n, wr_en, r_count < MAX_CNT, "store write while full")
    `URS_ASSERT_NEXT(a_clear_done, i_clk, i_rst_n, i_cmd.clear, (r_count == '0) && !r_dropped, "clear left state")

endmodule

`default_nettype wire

/* sv/urs_ctrl.sv */
// Controller of the usable range sort/merge block: sequences collection,
// default insertion, selection scans, merging and emission. Uses urs_pkg.
`default_nettype none
`include "usable_range_sort_merge_top_assert.svh"

module urs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_last_entry,
    output logic                o_in_stall,
    output urs_pkg::t_cmd       o_cmd,
    input  wire urs_pkg::t_stat i_stat
);

    typedef enum logic [3:0] {
        S_COLLECT,
        S_FLUSH,
        S_DEFAULT,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_MERGE,
        S_FINAL,
        S_EMPTY,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;

    // Commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_COLLECT: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_last_entry) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_DEFAULT;
            end
            S_DEFAULT: begin
                o_cmd.add_default = 1'b1;
                n_state           = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.count_zero ? S_EMPTY : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (!i_stat.merge_needs_out || i_stat.out_free) begin
                    o_cmd.merge = 1'b1;
                    n_state     = i_stat.picks_last ? S_FINAL : S_SCAN;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
        n_stall = (n_state != S_COLLECT);
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;

    `URS_ASSERT_IMPL(a_merge_room, i_clk, i_rst_n, o_cmd.merge && i_stat.merge_needs_out, i_stat.out_free, "merge emit with output busy")
    `URS_ASSERT_IMPL(a_accept_collect, i_clk, i_rst_n, o_cmd.accept, !o_in_stall, "accept while stalled")

endmodule

`default_nettype wire

/* sv/usable_range_sort_merge_top.sv */
// Usable range collector: filters memory map entries into a range store,
// then sorts and merges them into a list. Uses urs_pkg, urs_ctrl, urs_dpath.
//
// Map entries are accepted one per cycle while input is not stalled. After the
// transaction that carries last_entry, input stalls while the list is built:
// the store settles and the default range is added, then for each of the n
// stored ranges one scan of the store through its single read port picks the
// next lowest start; output stall can delay the list further, and an empty
// list skips the scans. The limit register is sampled live; the user must
// write it only while the block is idle, which the block does not enforce.
`default_nettype none

module usable_range_sort_merge_top #(
    parameter int MAX_RANGES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_entry_valid,
    input  wire logic [63:0] i_entry_addr,
    input  wire logic [63:0] i_entry_len,
    input  wire logic [31:0] i_entry_type,
    input  wire logic        i_last_entry,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_range_valid,
    output logic [31:0]      o_range_start,
    output logic [31:0]      o_range_end,
    output logic             o_range_last,
    output logic             o_ranges_dropped
);

    logic [31:0]    r_limit;
    urs_pkg::t_cmd  cmd;
    urs_pkg::t_stat stat;

    // Usable limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= urs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    urs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_entry (i_last_entry),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    urs_dpath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_limit          (r_limit),
        .i_entry_valid    (i_entry_valid),
        .i_entry_addr     (i_entry_addr),
        .i_entry_len      (i_entry_len),
        .i_entry_type     (i_entry_type),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_range_valid    (o_range_valid),
        .o_range_start    (o_range_start),
        .o_range_end      (o_range_end),
        .o_range_last     (o_range_last),
        .o_ranges_dropped (o_ranges_dropped)
    );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Testbench for usable_range_sort_merge_top: drives memory map entries and
// checks each merged range against a built-in predictor of filter, sort, merge.
// Depends on urs_pkg and the usable_range_sort_merge_top RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int          MAX_RANGES    = 32;
    localparam int          SETTLE_CYCLES = 16;
    localparam logic [31:0] TYPE_RESERVED = 32'd2;

    // One merged range as it leaves the block
    typedef struct {
        bit        valid;
        bit [31:0] lo;
        bit [31:0] hi;
        bit        last;
        bit        dropped;
    } t_range;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_entry_valid;
    logic [63:0] i_entry_addr;
    logic [63:0] i_entry_len;
    logic [31:0] i_entry_type;
    logic        i_last_entry;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_range_valid;
    logic [31:0] o_range_start;
    logic [31:0] o_range_end;
    logic        o_range_last;
    logic        o_ranges_dropped;

    // Predictor state: live limit, collected ranges, overflow flag
    bit [31:0] limit_shadow = urs_pkg::LIMIT_RESET;
    bit [31:0] held_lo [MAX_RANGES];
    bit [31:0] held_hi [MAX_RANGES];
    int        held_count = 0;
    bit        held_dropped = 1'b0;
    t_range    expected_ranges [$];

    int mismatch_count = 0;
    int send_pct = 0;
    int stall_pct = 0;

    usable_range_sort_merge_top #(.MAX_RANGES(MAX_RANGES)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_entry_valid   (i_entry_valid),
        .i_entry_addr    (i_entry_addr),
        .i_entry_len     (i_entry_len),
        .i_entry_type    (i_entry_type),
        .i_last_entry    (i_last_entry),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_range_valid   (o_range_valid),
        .o_range_start   (o_range_start),
        .o_range_end     (o_range_end),
        .o_range_last    (o_range_last),
        .o_ranges_dropped(o_ranges_dropped)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("** usable_range_sort_merge_top: FAILED **");
        $finish;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Filter one entry into the range set; on the map's last item build the
    // sorted, merged list and queue it as expected output
    function automatic void absorb_entry(bit ev, bit [63:0] addr, bit [63:0] len,
                                         bit [31:0] kind, bit last_item);
        bit [64:0] stop;
        bit [31:0] lo, hi, klo, khi;
        int        i, j, w;
        t_range    r;
        if (ev && len != 64'd0 && kind == urs_pkg::TYPE_AVAILABLE
                && addr < {32'd0, limit_shadow}) begin
            stop = {1'b0, addr} + {1'b0, len};
            lo   = addr[31:0];
            hi   = (stop > {33'd0, limit_shadow}) ? limit_shadow : stop[31:0];
            if (lo < hi) begin
                if (held_count >= MAX_RANGES) begin
                    held_dropped = 1'b1;
                end else begin
                    held_lo[held_count] = lo;
                    held_hi[held_count] = hi;
                    held_count++;
                end
            end
        end
        if (!last_item)
            return;

        // Nothing usable found: fall back to the whole window
        if (held_count == 0 && limit_shadow != 32'd0) begin
            held_lo[0] = 32'd0;
            held_hi[0] = limit_shadow;
            held_count = 1;
        end

        // Stable insertion sort by start
        for (i = 1; i < held_count; i++) begin
            klo = held_lo[i];
            khi = held_hi[i];
            j = i;
            while (j > 0 && held_lo[j-1] > klo) begin
                held_lo[j] = held_lo[j-1];
                held_hi[j] = held_hi[j-1];
                j--;
            end
            held_lo[j] = klo;
            held_hi[j] = khi;
        end

        // Merge overlapping or touching neighbors
        if (held_count > 1) begin
            w = 0;
            for (i = 1; i < held_count; i++) begin
                if (held_lo[i] <= held_hi[w]) begin
                    if (held_hi[i] > held_hi[w])
                        held_hi[w] = held_hi[i];
                end else begin
                    w++;
                    held_lo[w] = held_lo[i];
                    held_hi[w] = held_hi[i];
                end
            end
            held_count = w + 1;
        end

        if (held_count == 0) begin
            r = '{valid: 1'b0, lo: 32'd0, hi: 32'd0, last: 1'b1, dropped: held_dropped};
            expected_ranges.push_back(r);
        end else begin
            for (i = 0; i < held_count; i++) begin
                r = '{valid: 1'b1, lo: held_lo[i], hi: held_hi[i],
                      last: (i == held_count - 1), dropped: held_dropped};
                expected_ranges.push_back(r);
            end
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    function automatic void check_field(string name, bit [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Output checker: every accepted transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_range want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_ranges.size() == 0) begin
                $display("%0t ns: unexpected range, expected none, actual start %h end %h",
                         $time, o_range_start, o_range_end);
                mismatch_count++;
            end else begin
                want = expected_ranges.pop_front();
                check_field("range_valid", want.valid, o_range_valid);
                check_field("range_start", want.lo, o_range_start);
                check_field("range_end", want.hi, o_range_end);
                check_field("range_last", want.last, o_range_last);
                check_field("ranges_dropped", want.dropped, o_ranges_dropped);
            end
        end
    end

    // Send one entry transaction; returns at the edge where it was accepted
    task automatic send_entry(bit ev, bit [63:0] addr, bit [63:0] len,
                              bit [31:0] kind, bit last_item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_entry_valid = ev;
        i_entry_addr  = addr;
        i_entry_len   = len;
        i_entry_type  = kind;
        i_last_entry  = last_item;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        absorb_entry(ev, addr, len, kind, last_item);
    endtask

    // Drain all expected output, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(bit [31:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        limit_shadow = value;
    endtask

    function automatic bit [31:0] pick_limit();
        int c;
        c = $urandom_range(99);
        if (c < 8)
            return 32'd0;
        else if (c < 16)
            return 32'hFFFF_FFFF;
        else if (c < 24)
            return 32'd1;
        else if (c < 40)
            return $urandom_range(4096, 2);
        else if (c < 55)
            return urs_pkg::LIMIT_RESET;
        return $urandom;
    endfunction

    // Random entry, mostly kept and clustered so ranges overlap and touch
    task automatic make_entry(input bit flood, inout bit [31:0] prev_end,
                              output bit ev, output bit [63:0] addr,
                              output bit [63:0] len, output bit [31:0] kind);
        bit [31:0] gran, base;
        int        a, l, t;
        gran = (limit_shadow >= 32'd64) ? (limit_shadow >> 6) : 32'd1;
        a = $urandom_range(99);
        l = $urandom_range(99);
        t = $urandom_range(99);
        ev = flood || ($urandom_range(99) >= 6);

        if (flood || t < 80)
            kind = urs_pkg::TYPE_AVAILABLE;
        else if (t < 88)
            kind = $urandom;
        else if (t < 94)
            kind = 32'd0;
        else
            kind = TYPE_RESERVED;

        if (limit_shadow == 32'd0 || (!flood && a >= 90)) begin
            addr = {$urandom, $urandom};
        end else begin
            if (a < 25)
                base = prev_end;
            else
                base = gran * $urandom_range(63) + $urandom_range(7);
            addr = {32'd0, base % limit_shadow};
        end

        if (!flood && l < 5)
            len = 64'd0;
        else if (l < 10)
            len = {$urandom, $urandom};
        else
            len = {32'd0, gran * $urandom_range(4, 1) + $urandom_range(15)};
        if (len == 64'd0 && flood)
            len = 64'd1;

        prev_end = addr[31:0] + len[31:0];
    endtask

    // One random map; counts every item sent
    task automatic send_random_map(output int counted);
        bit        flood, ev;
        bit [31:0] prev_end, kind;
        bit [63:0] addr, len;
        int        size, k;
        flood    = ($urandom_range(99) < 8);
        size     = flood ? $urandom_range(40, 33) : $urandom_range(8, 1);
        prev_end = 32'd0;
        counted  = 0;
        for (k = 0; k < size; k++) begin
            // stray transaction with no entry
            if (!flood && $urandom_range(99) < 5) begin
                send_entry(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b0);
                counted++;
            end
            make_entry(flood, prev_end, ev, addr, len, kind);
            if (k == size - 1 && !flood && $urandom_range(99) < 10)
                ev = 1'b0;
            send_entry(ev, addr, len, kind, k == size - 1);
            counted++;
        end
    endtask

    // Filtering rules: skipped entries, clipping, carry past 64 bits
    task automatic test_entry_filtering();
        write_limit(urs_pkg::LIMIT_RESET);
        send_entry(1'b0, '1, '1, '1, 1'b0);
        send_entry(1'b1, 64'h1000, 64'd0, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h1000, 64'h100, TYPE_RESERVED, 1'b0);
        send_entry(1'b1, 64'h1000, 64'h100, 32'hFFFF_FFFF, 1'b0);
        send_entry(1'b1, {32'd0, urs_pkg::LIMIT_RESET}, 64'h100, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, '1, 64'd1, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h1FFF_F000, '1, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h100, 64'h100, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h200, 64'h100, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h180, 64'h10, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h0, 64'h80, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h1000, 64'h1000, urs_pkg::TYPE_AVAILABLE, 1'b1);
    endtask

    // Equal starts keep arrival order before merging
    task automatic test_stable_merge();
        send_entry(1'b1, 64'h5000, 64'h10, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h5000, 64'h100, urs_pkg::TYPE_AVAILABLE, 1'b0);
        send_entry(1'b1, 64'h5000, 64'h8, urs_pkg::TYPE_AVAILABLE, 1'b1);
    endtask

    // Fallback range when nothing was kept, and the limit extremes
    task automatic test_default_range();
        send_entry(1'b0, 64'd0, 64'd0, 32'd0, 1'b1);
        write_limit(32'hFFFF_FFFF);
        send_entry(1'b1, 64'hFFFF_FFFE, 64'h10, urs_pkg::TYPE_AVAILABLE, 1'b1);
        send_entry(1'b0, 64'd0, 64'd0, 32'd0, 1'b1);
        write_limit(32'd1);
        send_entry(1'b1, 64'd0, 64'd1, urs_pkg::TYPE_AVAILABLE, 1'b1);
    endtask

    // Zero limit: no range survives and the list comes back empty
    task automatic test_empty_list();
        write_limit(32'd0);
        send_entry(1'b1, 64'd0, 64'd5, urs_pkg::TYPE_AVAILABLE, 1'b1);
        send_entry(1'b0, 64'd0, 64'd0, 32'd0, 1'b1);
    endtask

    task automatic test_random_maps(int item_budget, int src_idle, int sink_idle);
        int sent, got, maps;
        send_pct  = src_idle;
        stall_pct = sink_idle;
        sent = 0;
        maps = 0;
        while (sent < item_budget) begin
            if (maps % 6 == 0)
                write_limit(pick_limit());
            send_random_map(got);
            sent += got;
            maps++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 32'd0;
        i_in_valid    = 1'b0;
        i_entry_valid = 1'b0;
        i_entry_addr  = 64'd0;
        i_entry_len   = 64'd0;
        i_entry_type  = 32'd0;
        i_last_entry  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_pct  = 14;
        stall_pct = 87;
        test_entry_filtering();
        test_stable_merge();
        test_default_range();
        test_empty_list();
        test_random_maps(136, 14, 87);
        test_random_maps(136, 87, 14);
        test_random_maps(137, 0, 0);
        wait_idle();

        if (mismatch_count == 0)
            $display("** usable_range_sort_merge_top: PASSED **");
        else
            $display("** usable_range_sort_merge_top: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/urs_pkg.sv
sv/urs_dpath.sv
sv/urs_ctrl.sv
sv/usable_range_sort_merge_top.sv
test/testbench.sv
